### hdl/sdeh_pkg.sv
// package for the step detector: payload types, register codes and constants
package sdeh_pkg;

	// widths of fields and registers
	localparam int MAG_W   = 16;
	localparam int TIME_W  = 32;
	localparam int COUNT_W = 32;
	localparam int REG_W   = 16;
	localparam int LEVEL_W = 24;
	localparam int CFG_IDX_W = 2;

	// gravity, 9.81 m/s^2 in Q8.8
	localparam logic [MAG_W-1:0] GRAVITY_Q8_8 = 16'd2511;

	// register reset values
	localparam logic [REG_W-1:0] ALPHA_RST     = 16'd13107;
	localparam logic [REG_W-1:0] THRESHOLD_RST = 16'd307;
	localparam logic [REG_W-1:0] MIN_GAP_RST   = 16'd250;
	localparam logic [REG_W-1:0] MAX_GAP_RST   = 16'd2000;

	// input commands
	typedef enum logic {
		CMD_FEED  = 1'b0,
		CMD_CLEAR = 1'b1
	} cmd_t;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EMA_ALPHA      = 2'd0,
		REG_STEP_THRESHOLD = 2'd1,
		REG_MIN_GAP_MS     = 2'd2,
		REG_MAX_GAP_MS     = 2'd3
	} reg_idx_t;

	// one input item
	typedef struct packed {
		cmd_t              cmd;
		logic [MAG_W-1:0]  magnitude;
		logic [TIME_W-1:0] time_ms;
	} in_item_t;

	// one result item
	typedef struct packed {
		logic [COUNT_W-1:0] step_count;
		logic               step_taken;
		logic               above_now;
	} out_item_t;

	// configuration bundle handed to the core
	typedef struct packed {
		logic [REG_W-1:0] ema_alpha;
		logic [REG_W-1:0] step_threshold;
		logic [REG_W-1:0] min_gap_ms;
		logic [REG_W-1:0] max_gap_ms;
	} cfg_t;

endpackage

### hdl/sdeh_ema.sv
// first-order ema update of the smoothed level, one multiply with rounding
module sdeh_ema
	import sdeh_pkg::*;
(
	input  logic [LEVEL_W-1:0] level,
	input  logic [LEVEL_W-1:0] target,
	input  logic [REG_W-1:0]   alpha,
	output logic [LEVEL_W-1:0] level_next
);

	localparam int PROD_W = LEVEL_W + REG_W;
	localparam logic [PROD_W-1:0] HALF_LSB = PROD_W'(1) << (REG_W - 1);

	logic                 rising;
	logic [LEVEL_W-1:0]   diff;
	logic [PROD_W-1:0]    prod;
	logic [PROD_W-1:0]    prod_rnd;
	logic [LEVEL_W-1:0]   delta;

	// magnitude of the step toward the target
	assign rising   = (target >= level);
	assign diff     = rising ? (target - level) : (level - target);
	assign prod     = PROD_W'(diff) * PROD_W'(alpha);
	// round half away from zero, then back to q8.16
	assign prod_rnd = prod + HALF_LSB;
	assign delta    = prod_rnd[PROD_W-1:REG_W];

	// apply the sign of the difference
	assign level_next = rising ? (level + delta) : (level - delta);

endmodule

### hdl/sdeh_core.sv
// detector state: smoothed level, hysteresis flag, step count and last step time
module sdeh_core
	import sdeh_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  in_item_t  item,
	input  cfg_t      cfg,
	output out_item_t res
);

	logic [COUNT_W-1:0] steps_q;
	logic [LEVEL_W-1:0] level_q;
	logic               above_q;
	logic [TIME_W-1:0]  last_q;

	logic [MAG_W-1:0]   dev;
	logic [LEVEL_W-1:0] dev_wide;
	logic [LEVEL_W-1:0] level_upd;
	logic [TIME_W-1:0]  elapsed;
	logic               rise_hit;
	logic               fall_hit;
	logic               gap_ok;
	logic               gap_over;

	logic [COUNT_W-1:0] steps_d;
	logic [LEVEL_W-1:0] level_d;
	logic               above_d;
	logic [TIME_W-1:0]  last_d;
	logic               taken_d;

	// absolute deviation from gravity, widened to q8.16
	assign dev      = (item.magnitude >= GRAVITY_Q8_8) ? (item.magnitude - GRAVITY_Q8_8)
	                                                    : (GRAVITY_Q8_8 - item.magnitude);
	assign dev_wide = {dev, 8'd0};

	sdeh_ema u_ema (
		.level      (level_q),
		.target     (dev_wide),
		.alpha      (cfg.ema_alpha),
		.level_next (level_upd)
	);

	// threshold and gap tests on the updated level
	assign elapsed  = item.time_ms - last_q;
	assign rise_hit = (level_upd >= {cfg.step_threshold, 8'd0});
	assign fall_hit = (level_upd < {1'b0, cfg.step_threshold, 7'd0});
	assign gap_ok   = (elapsed >= TIME_W'(cfg.min_gap_ms));
	assign gap_over = (elapsed > TIME_W'(cfg.max_gap_ms));

	// next state and result
	always_comb begin
		steps_d = steps_q;
		level_d = level_q;
		above_d = above_q;
		last_d  = last_q;
		taken_d = 1'b0;
		case (item.cmd)
			CMD_CLEAR: begin
				steps_d = '0;
				level_d = '0;
				above_d = 1'b0;
				last_d  = '0;
			end
			CMD_FEED: begin
				level_d = level_upd;
				if (!above_q) begin
					if (rise_hit) begin
						above_d = 1'b1;
						if (gap_ok) begin
							steps_d = steps_q + 1'b1;
							last_d  = item.time_ms;
							taken_d = 1'b1;
						end
					end
				end else begin
					if (fall_hit || gap_over) begin
						above_d = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign res.step_count = steps_d;
	assign res.step_taken = taken_d;
	assign res.above_now  = above_d;

	// state registers, updated once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= '0;
			level_q <= '0;
			above_q <= 1'b0;
			last_q  <= '0;
		end else if (fire) begin
			steps_q <= steps_d;
			level_q <= level_d;
			above_q <= above_d;
			last_q  <= last_d;
		end
	end

endmodule

### hdl/step_detector_ema_hysteresis.sv
// top level: sample input stage, configuration registers, detector core, result register
// Step detector on acceleration magnitude: each sample is taken into an input register, and
// while it is held there its deviation from gravity is smoothed by an ema and run through a
// two-state hysteresis detector, with the result written to an output register. One sample
// is accepted every cycle while the result register is free or being drained, and its result
// is offered from the result register; results come out in order, one per sample. The clock
// period is set by the smoothed-level feedback path: a 24-bit subtract, a 24x16 multiply,
// rounding, an add and the threshold compares. A clear command zeroes the count, the filter
// and the detector state and reports zeros. The user must write registers through the cfg
// port only while no sample is in flight; the block itself does not enforce it.
module step_detector_ema_hysteresis
	import sdeh_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_ready,
	input  in_item_t             sample,
	output logic                 result_valid,
	input  logic                 result_ready,
	output out_item_t            result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data
);

	cfg_t      cfg_q;
	logic      valid_s1;
	in_item_t  item_s1;
	logic      res_valid_q;
	out_item_t res_q;
	out_item_t res_d;
	logic      out_free;
	logic      fire;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ema_alpha      <= ALPHA_RST;
			cfg_q.step_threshold <= THRESHOLD_RST;
			cfg_q.min_gap_ms     <= MIN_GAP_RST;
			cfg_q.max_gap_ms     <= MAX_GAP_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_EMA_ALPHA:      cfg_q.ema_alpha      <= cfg_data;
				REG_STEP_THRESHOLD: cfg_q.step_threshold <= cfg_data;
				REG_MIN_GAP_MS:     cfg_q.min_gap_ms     <= cfg_data;
				REG_MAX_GAP_MS:     cfg_q.max_gap_ms     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// handshake: stage 1 moves on when the result register is free or being drained
	assign out_free     = !res_valid_q || result_ready;
	assign fire         = valid_s1 && out_free;
	assign sample_ready = !valid_s1 || out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			item_s1 <= sample;
		end
	end

	sdeh_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res_d)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_d;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

`ifndef ASSERT_OFF
	// a counted step always leaves the detector in the above state
	a_step_implies_above: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (!result.step_taken || result.above_now))
		else $error("step counted without above state");

	// a clear command reports an all-zero result
	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item_s1.cmd == CMD_CLEAR) |=>
		(result.step_count == '0 && !result.step_taken && !result.above_now))
		else $error("clear transfer did not report zeros");

	// an empty input register never blocks a new transfer
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> sample_ready)
		else $error("input stalled while empty");

	// the count moves by the step flag only
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item_s1.cmd == CMD_FEED && res_valid_q && result_ready) |=>
		(result.step_count == $past(result.step_count) + COUNT_W'(result.step_taken)))
		else $error("step count changed without a step");
`endif

endmodule
